[design/lst_pkg.sv]
// shared types, constants and helpers for the lms trainer
`default_nettype none
package lst_pkg;

  localparam int VAL_W    = 16;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 5;
  localparam int STEP_W   = 16;
  localparam int SUB_W    = 4;
  localparam int MAX_IN   = 16;
  localparam int MAX_OUT  = 16;
  localparam int WSTORE_D = 256;
  localparam int ACC_W    = 36;
  localparam int SQ_W     = 30;

  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_FEATURE = 2'd2,
    OP_TARGET  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_INPUT_COUNT  = 2'd0,
    REG_OUTPUT_COUNT = 2'd1,
    REG_STEP         = 2'd2
  } reg_idx_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    learn;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  n_in;
    logic [CNT_W-1:0]  n_out;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOT_ADDR,
    S_DOT_MAC,
    S_OUT_Y,
    S_OUT_ERR,
    S_OUT_SQ,
    S_EMIT,
    S_BIAS,
    S_UPD_ADDR,
    S_UPD_MUL,
    S_UPD_WR
  } state_t;

  // clamp a wide signed value to the q4.12 range
  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7fff;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

  // register count with zero taken as one and large values capped
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c,
                                                  input logic [CNT_W-1:0] maxc);
    if (c == '0) begin
      return CNT_W'(1);
    end else if (c > maxc) begin
      return maxc;
    end else begin
      return c;
    end
  endfunction

endpackage
`default_nettype wire

[design/lst_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module lst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule
`default_nettype wire

[design/lst_front.sv]
// front end: accepts input transfers, decodes them and queues them for the engine
`default_nettype none
module lst_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_operation,
  input  wire logic [lst_pkg::IDX_W-1:0]       in_index,
  input  wire logic signed [lst_pkg::VAL_W-1:0] in_value,
  input  wire logic                            in_learn,
  output logic                                 cmd_valid,
  output lst_pkg::cmd_t                        cmd,
  input  wire logic                            cmd_pop
);
  import lst_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       in_cmd;

  // classify the incoming item
  always_comb begin
    in_cmd.op    = op_t'(in_operation);
    in_cmd.index = in_index;
    in_cmd.value = in_value;
    in_cmd.learn = in_learn;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  // pointer and fill bookkeeping
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_cmd;
    end
  end
endmodule
`default_nettype wire

[design/lst_engine.sv]
// back end: carries out loads, forward pass, error and delta rule update
`default_nettype none
module lst_engine (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cmd_valid,
  input  wire lst_pkg::cmd_t                    cmd,
  output logic                                  cmd_pop,
  input  wire lst_pkg::cfg_t                    cfg,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic signed [lst_pkg::VAL_W-1:0]      out_output_value,
  output logic signed [lst_pkg::VAL_W-1:0]      out_error_value,
  output logic        [lst_pkg::SQ_W-1:0]       out_half_square_error,
  output logic                                  out_last_of_sample
);
  import lst_pkg::*;

  localparam int WA_W = $clog2(WSTORE_D);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        fpos_r, fpos_nxt;
  logic [CNT_W-1:0]        tpos_r, tpos_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]        o_r, o_nxt;
  logic                    learn_r, learn_nxt;
  logic                    last_r, last_nxt;
  logic signed [VAL_W-1:0] t_r, t_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [VAL_W-1:0] y_r, y_nxt;
  logic signed [VAL_W-1:0] err_r, err_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic signed [31:0]      prod1_r, prod1_nxt;
  logic signed [48:0]      prod2_r, prod2_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_y_r, out_err_r;
  logic [SQ_W-1:0]         out_sq_r;
  logic                    out_last_r;
  logic                    out_load;

  logic signed [VAL_W-1:0] bias_r [MAX_OUT];
  logic signed [VAL_W-1:0] feat_r [MAX_IN];
  logic                    bias_we, feat_we;
  logic [SUB_W-1:0]        bias_wa, feat_wa;
  logic signed [VAL_W-1:0] bias_wd, feat_wd;

  logic                    ram_we, ram_re;
  logic [WA_W-1:0]         ram_wa, ram_ra;
  logic [VAL_W-1:0]        ram_wd, ram_rd;

  logic signed [31:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [48:0]      mul_p;

  logic signed [VAL_W-1:0] f_cur, b_cur, w_cur;
  logic signed [ACC_W-1:0] ysum, ysh;
  logic signed [16:0]      ediff;
  logic signed [48:0]      br, dsh;
  logic [CNT_W-1:0]        fp_w, fp_inc, o_sel;

  lst_ram #(.WIDTH(VAL_W), .DEPTH(WSTORE_D)) u_wram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .re(ram_re), .raddr(ram_ra), .rdata(ram_rd)
  );

  // the one shared multiplier
  assign mul_p = mul_a * mul_b;

  assign f_cur = feat_r[i_r[SUB_W-1:0]];
  assign b_cur = bias_r[o_r[SUB_W-1:0]];
  assign w_cur = $signed(ram_rd);
  assign ysum  = acc_r - (ACC_W'(b_cur) <<< 12) + 36'sd2048;
  assign ysh   = ysum >>> 12;
  assign ediff = 17'(y_r) - 17'(t_r);
  assign br    = (mul_p + 49'sd32768) >>> 16;
  assign dsh   = (prod2_r + 49'sd134217728) >>> 28;
  assign fp_w  = (fpos_r >= cfg.n_in) ? '0 : fpos_r;
  assign fp_inc = fp_w + CNT_W'(1);
  assign o_sel = (tpos_r >= cfg.n_out) ? '0 : tpos_r;
  assign ram_ra = WA_W'({o_r[SUB_W-1:0], i_r[SUB_W-1:0]});

  // sequencer: next state, datapath control and store writes
  always_comb begin
    state_nxt = state_r;
    fpos_nxt  = fpos_r;
    tpos_nxt  = tpos_r;
    i_nxt     = i_r;
    o_nxt     = o_r;
    learn_nxt = learn_r;
    last_nxt  = last_r;
    t_nxt     = t_r;
    acc_nxt   = acc_r;
    y_nxt     = y_r;
    err_nxt   = err_r;
    sq_nxt    = sq_r;
    prod1_nxt = prod1_r;
    prod2_nxt = prod2_r;
    out_load  = 1'b0;
    cmd_pop   = 1'b0;
    bias_we   = 1'b0;
    bias_wa   = o_r[SUB_W-1:0];
    bias_wd   = b_cur;
    feat_we   = 1'b0;
    feat_wa   = fp_w[SUB_W-1:0];
    feat_wd   = cmd.value;
    ram_we    = 1'b0;
    ram_wa    = ram_ra;
    ram_wd    = ram_rd;
    ram_re    = 1'b0;
    mul_a     = 32'(f_cur);
    mul_b     = 17'(err_r);
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_WEIGHT: begin
              ram_we = 1'b1;
              ram_wa = WA_W'(cmd.index);
              ram_wd = cmd.value;
            end
            OP_BIAS: begin
              if (cmd.index < IDX_W'(MAX_OUT)) begin
                bias_we = 1'b1;
                bias_wa = cmd.index[SUB_W-1:0];
                bias_wd = cmd.value;
              end
            end
            OP_FEATURE: begin
              feat_we  = 1'b1;
              fpos_nxt = (fp_inc >= cfg.n_in) ? '0 : fp_inc;
            end
            OP_TARGET: begin
              o_nxt     = o_sel;
              t_nxt     = cmd.value;
              learn_nxt = cmd.learn;
              last_nxt  = (o_sel + CNT_W'(1) == cfg.n_out);
              acc_nxt   = '0;
              i_nxt     = '0;
              state_nxt = S_DOT_ADDR;
            end
            default: begin
            end
          endcase
        end
      end
      S_DOT_ADDR: begin
        ram_re    = 1'b1;
        state_nxt = S_DOT_MAC;
      end
      S_DOT_MAC: begin
        mul_a   = 32'(f_cur);
        mul_b   = 17'(w_cur);
        acc_nxt = acc_r + ACC_W'(mul_p);
        i_nxt   = i_r + CNT_W'(1);
        state_nxt = (i_r + CNT_W'(1) == cfg.n_in) ? S_OUT_Y : S_DOT_ADDR;
      end
      S_OUT_Y: begin
        y_nxt     = sat16(40'(ysh));
        state_nxt = S_OUT_ERR;
      end
      S_OUT_ERR: begin
        err_nxt   = sat16(40'(ediff));
        state_nxt = S_OUT_SQ;
      end
      S_OUT_SQ: begin
        mul_a     = 32'(err_r);
        mul_b     = 17'(err_r);
        sq_nxt    = mul_p[SQ_W:1];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          tpos_nxt  = last_r ? '0 : o_r + CNT_W'(1);
          state_nxt = learn_r ? S_BIAS : S_IDLE;
        end
      end
      S_BIAS: begin
        mul_a     = 32'(err_r);
        mul_b     = $signed({1'b0, cfg.step});
        bias_we   = 1'b1;
        bias_wd   = sat16(40'(b_cur) + 40'(br));
        i_nxt     = '0;
        state_nxt = S_UPD_ADDR;
      end
      S_UPD_ADDR: begin
        ram_re    = 1'b1;
        mul_a     = 32'(f_cur);
        mul_b     = 17'(err_r);
        prod1_nxt = 32'(mul_p);
        state_nxt = S_UPD_MUL;
      end
      S_UPD_MUL: begin
        mul_a     = prod1_r;
        mul_b     = $signed({1'b0, cfg.step});
        prod2_nxt = mul_p;
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        ram_we    = 1'b1;
        ram_wd    = sat16(40'(w_cur) - 40'(dsh));
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = (i_r + CNT_W'(1) == cfg.n_in) ? S_IDLE : S_UPD_ADDR;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fpos_r      <= '0;
      tpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fpos_r      <= fpos_nxt;
      tpos_r      <= tpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    o_r     <= o_nxt;
    learn_r <= learn_nxt;
    last_r  <= last_nxt;
    t_r     <= t_nxt;
    acc_r   <= acc_nxt;
    y_r     <= y_nxt;
    err_r   <= err_nxt;
    sq_r    <= sq_nxt;
    prod1_r <= prod1_nxt;
    prod2_r <= prod2_nxt;
    if (out_load) begin
      out_y_r    <= y_r;
      out_err_r  <= err_r;
      out_sq_r   <= sq_r;
      out_last_r <= last_r;
    end
    if (bias_we) begin
      bias_r[bias_wa] <= bias_wd;
    end
    if (feat_we) begin
      feat_r[feat_wa] <= feat_wd;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_output_value      = out_y_r;
  assign out_error_value       = out_err_r;
  assign out_half_square_error = out_sq_r;
  assign out_last_of_sample    = out_last_r;

  // checks
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid && state_r == S_IDLE) else $error("pop without queued command");
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r) else $error("result not presented after load");
  a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOT_MAC || state_r == S_UPD_WR) |-> i_r < cfg.n_in)
    else $error("element counter past input count");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_ready) else $error("result overwritten");
endmodule
`default_nettype wire

[design/lms_single_layer_trainer_core.sv]
// Top level of the lms trainer: register port, front queue and engine.
// Input channel (in_*): one transfer per item; loads of weights or biases and
//   feature items are done in the engine's idle state; a two-entry queue takes
//   items while the engine is busy.
// Target items run the forward pass and produce one result transfer (out_*),
//   paced by one shared multiplier and the registered read of the weight ram;
//   with learning on, the engine then updates the bias and the weight row.
// Registers on the apb-style port: input count at 0x0, output count at 0x4,
//   learning step at 0x8; write only while idle.
// Reset (synchronous, rst_n low) clears positions, queue and result valid;
//   weight, bias and feature stores hold nothing until written.
// A stalled receiver holds the result in the output register; the engine waits
//   to emit a later result while it is full; the queue takes items until full.
`default_nettype none
module lms_single_layer_trainer_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [3:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_operation,
  input  wire logic [lst_pkg::IDX_W-1:0]        in_index,
  input  wire logic signed [lst_pkg::VAL_W-1:0] in_value,
  input  wire logic                             in_learn,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [lst_pkg::VAL_W-1:0]      out_output_value,
  output logic signed [lst_pkg::VAL_W-1:0]      out_error_value,
  output logic        [lst_pkg::SQ_W-1:0]       out_half_square_error,
  output logic                                  out_last_of_sample
);
  import lst_pkg::*;

  logic [CNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              wr_en;
  reg_idx_t          reg_sel;
  cfg_t              cfg;
  cmd_t              cmd;
  logic              cmd_valid, cmd_pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  // register writes
  always_comb begin
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    step_nxt    = step_r;
    if (wr_en) begin
      case (reg_sel)
        REG_INPUT_COUNT:  in_cnt_nxt  = pwdata[CNT_W-1:0];
        REG_OUTPUT_COUNT: out_cnt_nxt = pwdata[CNT_W-1:0];
        REG_STEP:         step_nxt    = pwdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= CNT_W'(16);
      out_cnt_r <= CNT_W'(16);
      step_r    <= STEP_W'(655);
    end else begin
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      step_r    <= step_nxt;
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      REG_INPUT_COUNT:  prdata = 32'(in_cnt_r);
      REG_OUTPUT_COUNT: prdata = 32'(out_cnt_r);
      REG_STEP:         prdata = 32'(step_r);
      default:          prdata = '0;
    endcase
  end

  // effective counts
  always_comb begin
    cfg.n_in  = clamp_cnt(in_cnt_r, CNT_W'(MAX_IN));
    cfg.n_out = clamp_cnt(out_cnt_r, CNT_W'(MAX_OUT));
    cfg.step  = step_r;
  end

  lst_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_index(in_index),
    .in_value(in_value), .in_learn(in_learn),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  lst_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .cfg(cfg), .out_ready(out_ready), .out_valid(out_valid),
    .out_output_value(out_output_value), .out_error_value(out_error_value),
    .out_half_square_error(out_half_square_error),
    .out_last_of_sample(out_last_of_sample)
  );
endmodule
`default_nettype wire

[tb/lms_single_layer_trainer_core_test.sv]
// testbench for the lms trainer core: directed table, random samples, result scoreboard
module lms_single_layer_trainer_core_test;
  import lst_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 200;

  typedef struct packed {
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] err;
    logic [SQ_W-1:0]         sq;
    logic                    last;
  } neuron_res_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic                    learn;
    logic                    typed;
    neuron_res_t             res;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    psel, penable, pwrite;
  logic [3:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_operation;
  logic [IDX_W-1:0]        in_index;
  logic signed [VAL_W-1:0] in_value;
  logic                    in_learn;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_output_value;
  logic signed [VAL_W-1:0] out_error_value;
  logic [SQ_W-1:0]         out_half_square_error;
  logic                    out_last_of_sample;

  // shadow of the network state and registers
  logic signed [VAL_W-1:0] weights [WSTORE_D];
  logic signed [VAL_W-1:0] biases [MAX_OUT];
  logic signed [VAL_W-1:0] features [MAX_IN];
  int unsigned feat_pos, tgt_pos;
  int unsigned cfg_inputs, cfg_outputs, cfg_step;

  neuron_res_t pending_results[$];
  stim_row_t   dir_rows[$];
  int unsigned errors;
  int unsigned cycles;
  bit          gaps_on;

  lms_single_layer_trainer_core u_top (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_operation, .in_index, .in_value, .in_learn,
    .out_valid, .out_ready, .out_output_value, .out_error_value,
    .out_half_square_error, .out_last_of_sample
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned eff_count(input int unsigned c);
    if (c == 0) return 1;
    if (c > 16) return 16;
    return c;
  endfunction

  function automatic logic signed [VAL_W-1:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[VAL_W-1:0];
  endfunction

  // round half up at a binary point: add half then arithmetic shift
  function automatic longint round_at(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // delta rule step for one accepted item; returns 1 when a result is due
  function automatic bit train_step(input op_t op, input logic [IDX_W-1:0] idx,
                                    input logic signed [VAL_W-1:0] val, input logic learn,
                                    output neuron_res_t res);
    int unsigned n_in, n_out, o, i;
    longint acc, y, e, d;
    n_in  = eff_count(cfg_inputs);
    n_out = eff_count(cfg_outputs);
    res   = '0;
    case (op)
      OP_WEIGHT: begin
        weights[idx] = val;
        return 0;
      end
      OP_BIAS: begin
        if (idx < MAX_OUT) biases[idx] = val;
        return 0;
      end
      OP_FEATURE: begin
        if (feat_pos >= n_in) feat_pos = 0;
        features[feat_pos] = val;
        feat_pos = feat_pos + 1;
        if (feat_pos >= n_in) feat_pos = 0;
        return 0;
      end
      default: begin
        if (tgt_pos >= n_out) tgt_pos = 0;
        o = tgt_pos;
        acc = 0;
        for (i = 0; i < n_in; i++)
          acc += longint'(features[i]) * longint'(weights[o*MAX_IN + i]);
        acc -= longint'(biases[o]) <<< 12;
        y = clip16(round_at(acc, 12));
        e = clip16(y - longint'(val));
        res.y    = y[VAL_W-1:0];
        res.err  = e[VAL_W-1:0];
        res.sq   = SQ_W'((e * e) >> 1);
        res.last = (o + 1 == n_out);
        if (learn) begin
          biases[o] = clip16(longint'(biases[o]) + round_at(longint'(cfg_step) * e, 16));
          for (i = 0; i < n_in; i++) begin
            d = round_at(longint'(cfg_step) * (longint'(features[i]) * e), 28);
            weights[o*MAX_IN + i] = clip16(longint'(weights[o*MAX_IN + i]) - d);
          end
        end
        tgt_pos = res.last ? 0 : o + 1;
        return 1;
      end
    endcase
  endfunction

  // one input transfer; a typed expectation replaces the predicted one
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val, input logic learn,
                           input bit typed, input neuron_res_t typed_res);
    int unsigned gap;
    neuron_res_t res;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_index     <= idx;
    in_value     <= val;
    in_learn     <= learn;
    do @(posedge clk); while (!in_ready);
    if (train_step(op, idx, val, learn, res))
      pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, setup then access
  task automatic write_reg(input reg_idx_t r, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_INPUT_COUNT:  cfg_inputs  = data[4:0];
      REG_OUTPUT_COUNT: cfg_outputs = data[4:0];
      default:          cfg_step    = data[15:0];
    endcase
  endtask

  task automatic set_config(input int unsigned ni, input int unsigned no, input int unsigned st);
    write_reg(REG_INPUT_COUNT, ni);
    write_reg(REG_OUTPUT_COUNT, no);
    write_reg(REG_STEP, st);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return VAL_W'($urandom);
      default: return VAL_W'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic stim_row_t row(input op_t op, input logic [IDX_W-1:0] idx,
                                    input logic [VAL_W-1:0] val, input logic learn);
    stim_row_t r;
    r = '0;
    r.op = op; r.idx = idx; r.val = val; r.learn = learn;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [VAL_W-1:0] val,
                                            input logic [VAL_W-1:0] y,
                                            input logic [VAL_W-1:0] e,
                                            input logic [SQ_W-1:0] sq, input logic last);
    stim_row_t r;
    r = row(OP_TARGET, 8'h00, val, 1'b0);
    r.typed = 1'b1;
    r.res.y = y; r.res.err = e; r.res.sq = sq; r.res.last = last;
    return r;
  endfunction

  // result side: random stalls, compare against the oldest expectation
  initial begin
    int unsigned stall;
    neuron_res_t want;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transfer y %0d", $time, out_output_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_output_value !== want.y) begin
          $display("%0t output_value expected %0d actual %0d", $time, want.y, out_output_value);
          errors++;
        end
        if (out_error_value !== want.err) begin
          $display("%0t error_value expected %0d actual %0d", $time, want.err, out_error_value);
          errors++;
        end
        if (out_half_square_error !== want.sq) begin
          $display("%0t half_square_error expected %0d actual %0d", $time, want.sq,
                   out_half_square_error);
          errors++;
        end
        if (out_last_of_sample !== want.last) begin
          $display("%0t last_of_sample expected %0b actual %0b", $time, want.last,
                   out_last_of_sample);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned phase, k, n_in, n_out;
    int unsigned cfg_set [6][3];
    stim_row_t r;
    errors = 0; cycles = 0; gaps_on = 1'b1;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; in_operation = OP_WEIGHT; in_index = '0; in_value = '0; in_learn = 1'b0;
    feat_pos = 0; tgt_pos = 0;
    cfg_inputs = 16; cfg_outputs = 16; cfg_step = 655;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // clear every store so no entry is read unwritten
    for (k = 0; k < WSTORE_D; k++) send_item(OP_WEIGHT, IDX_W'(k), '0, 1'b0, 1'b0, '0);
    for (k = 0; k < MAX_OUT; k++) send_item(OP_BIAS, IDX_W'(k), '0, 1'b0, 1'b0, '0);
    for (k = 0; k < MAX_IN; k++) send_item(OP_FEATURE, 8'hff, '0, 1'b0, 1'b0, '0);

    // directed table: zero network first, then extremes and ignored indexes
    dir_rows.push_back(checked_row(16'h8000, 16'h0000, 16'h7fff, 30'd536838144, 1'b0));
    dir_rows.push_back(checked_row(16'h7fff, 16'h0000, 16'h8001, 30'd536838144, 1'b0));
    dir_rows.push_back(row(OP_WEIGHT, 8'd0, 16'h7fff, 1'b1));
    dir_rows.push_back(row(OP_WEIGHT, 8'd255, 16'h8000, 1'b0));
    dir_rows.push_back(row(OP_WEIGHT, 8'd34, 16'h1000, 1'b0));
    dir_rows.push_back(row(OP_BIAS, 8'd15, 16'h7fff, 1'b0));
    dir_rows.push_back(row(OP_BIAS, 8'd16, 16'h1234, 1'b0));
    dir_rows.push_back(row(OP_BIAS, 8'd255, 16'h8000, 1'b0));
    dir_rows.push_back(row(OP_BIAS, 8'd2, 16'h8000, 1'b0));
    dir_rows.push_back(row(OP_FEATURE, 8'hff, 16'h7fff, 1'b1));
    dir_rows.push_back(row(OP_FEATURE, 8'h00, 16'h8000, 1'b0));
    dir_rows.push_back(row(OP_FEATURE, 8'h5a, 16'h1000, 1'b0));
    dir_rows.push_back(row(OP_TARGET, 8'hff, 16'h0000, 1'b1));
    dir_rows.push_back(row(OP_TARGET, 8'h00, 16'h8000, 1'b1));
    dir_rows.push_back(row(OP_TARGET, 8'h00, 16'h7fff, 1'b0));
    dir_rows.push_back(row(OP_TARGET, 8'h00, 16'h1000, 1'b1));
    dir_rows.push_back(row(OP_WEIGHT, 8'd80, 16'h7fff, 1'b0));
    dir_rows.push_back(row(OP_TARGET, 8'h00, 16'h8000, 1'b1));
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_item(r.op, r.idx, r.val, r.learn, r.typed, r.res);
    end
    // hold the sender until every result is back
    drain();

    // register settings: zero counts, over-range counts, extremes of the step
    cfg_set = '{'{0, 0, 0}, '{31, 31, 65535}, '{1, 16, 65535}, '{16, 1, 1},
                '{5, 3, 655}, '{17, 2, 40000}};
    for (phase = 0; phase < 7; phase++) begin
      gaps_on = (phase % 2 == 0);
      if (phase < 6) set_config(cfg_set[phase][0], cfg_set[phase][1], cfg_set[phase][2]);
      else set_config($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 65535));
      n_in  = eff_count(cfg_inputs);
      n_out = eff_count(cfg_outputs);
      k = 0;
      while (k < 125) begin
        case ($urandom_range(0, 9))
          0: begin
            // noise item
            send_item(op_t'($urandom_range(0, 3)), IDX_W'($urandom), rand_value(),
                      1'($urandom), 1'b0, '0);
            k++;
          end
          1: begin
            send_item($urandom_range(0, 1) ? OP_WEIGHT : OP_BIAS, IDX_W'($urandom),
                      rand_value(), 1'($urandom), 1'b0, '0);
            k++;
          end
          default: begin
            // well-formed sample: all features then all targets
            for (int f = 0; f < n_in; f++)
              send_item(OP_FEATURE, IDX_W'($urandom), rand_value(), 1'($urandom), 1'b0, '0);
            for (int t = 0; t < n_out; t++)
              send_item(OP_TARGET, IDX_W'($urandom), rand_value(), 1'($urandom), 1'b0, '0);
            k += n_in + n_out;
          end
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[lms_single_layer_trainer_core.f]
design/lst_pkg.sv
design/lst_ram.sv
design/lst_front.sv
design/lst_engine.sv
design/lms_single_layer_trainer_core.sv
tb/lms_single_layer_trainer_core_test.sv
